// ===== rtl/adts_frame_sync_parser_macros.svh =====
// Assertion macros for the checker file of the frame sync parser.
`ifndef ADTS_FRAME_SYNC_PARSER_MACROS_SVH
`define ADTS_FRAME_SYNC_PARSER_MACROS_SVH

// Clocked implication check that is quiet while reset is held.
`define AFSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define AFSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/adts_fsp_pkg.sv =====
package adts_fsp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_INFO  = 2'd1;
  localparam logic [1:0] KIND_LOST  = 2'd2;
  localparam logic [1:0] KIND_SHORT = 2'd3;

  // Event codes between the front and the back.
  localparam logic [1:0] EV_BYTE = 2'd0;  // one frame byte
  localparam logic [1:0] EV_PAIR = 2'd1;  // sync byte 0xFF, then data
  localparam logic [1:0] EV_INFO = 2'd2;  // data byte, then header info
  localparam logic [1:0] EV_LOST = 2'd3;  // sync not found

  // Parser phases.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] SYNC_MASK = 8'hF6;
  localparam logic [7:0] SYNC_VAL  = 8'hF0;

  localparam int HDR_MAX = 10;
  localparam int INC_W   = 14;
  localparam int TS_W    = 33;

  typedef struct packed {
    logic            mpeg_id;
    logic [1:0]      profile;
    logic [3:0]      rate_index;
    logic [2:0]      channels;
    logic [12:0]     frame_length;
    logic [10:0]     buffer_fullness;
    logic [15:0]     check_word;
    logic [9:0]      misc_flags;
    logic [TS_W-1:0] timestamp;
  } hdr_t;

  typedef struct packed {
    logic [1:0] code;
    logic [7:0] data;
    logic       last;
    logic [1:0] info_kind;
    hdr_t       hdr;
  } evt_t;

endpackage

// ===== rtl/adts_frame_sync_parser.sv =====
// ADTS frame sync parser: takes one stream byte per clock on in_data_byte whenever the
// event queue has room, hunts for the ADTS sync word, and passes every byte of each
// frame out as a kind 0 request with the final byte marked, followed after the
// header's last byte by a kind 1 request carrying the parsed header and the frame's
// 33-bit 90 kHz timestamp. A kind 2 request reports that max_skip bytes went by
// without sync, after which input is taken and dropped until reset; kind 3 reports a
// frame_length shorter than its own header. The output side delivers one request per
// cycle while out_ready is high; the sync pair and the header-end byte each become two
// requests, and the event queue absorbs the difference. A write on cfg_max_skip updates
// max_skip and is accepted in any cycle.
module adts_frame_sync_parser #(
  parameter int SAMPLES_PER_FRAME = 1024,
  parameter int QUEUE_DEPTH       = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [12:0]  cfg_max_skip,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_data_byte,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   out_kind,
  output logic [7:0]   out_frame_byte,
  output logic         out_last_of_frame,
  output logic         out_mpeg_id,
  output logic [1:0]   out_profile,
  output logic [3:0]   out_rate_index,
  output logic [2:0]   out_channels,
  output logic [12:0]  out_frame_length,
  output logic [10:0]  out_buffer_fullness,
  output logic [15:0]  out_check_word,
  output logic [9:0]   out_misc_flags,
  output logic [32:0]  out_timestamp
);

  localparam int EVT_W = $bits(adts_fsp_pkg::evt_t);

  logic [12:0]        max_skip_r;
  logic               q_not_full, q_not_empty, q_push, q_pop;
  adts_fsp_pkg::evt_t ev, head;
  logic [EVT_W-1:0]   head_bits;
  adts_fsp_pkg::hdr_t hdr;

  // The register write is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_skip_r <= 13'd8000;
    end else if (cfg_valid) begin
      max_skip_r <= cfg_max_skip;
    end
  end

  // The front classifies each byte and turns it into at most one event.
  adts_fsp_front #(.SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .max_skip     (max_skip_r),
    .q_not_full   (q_not_full),
    .ev_push      (q_push),
    .ev           (ev)
  );

  // The queue lets the front run on while the back expands an event into two requests.
  adts_fsp_queue #(.WIDTH(EVT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (ev),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_bits)
  );

  assign head = head_bits;

  // The back expands each event into one or two requests in the output register.
  adts_fsp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .head              (head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_frame_byte    (out_frame_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_hdr           (hdr)
  );

  assign out_mpeg_id         = hdr.mpeg_id;
  assign out_profile         = hdr.profile;
  assign out_rate_index      = hdr.rate_index;
  assign out_channels        = hdr.channels;
  assign out_frame_length    = hdr.frame_length;
  assign out_buffer_fullness = hdr.buffer_fullness;
  assign out_check_word      = hdr.check_word;
  assign out_misc_flags      = hdr.misc_flags;
  assign out_timestamp       = hdr.timestamp;

endmodule

// ===== rtl/adts_fsp_queue.sv =====
module adts_fsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== rtl/adts_fsp_front.sv =====
module adts_fsp_front #(
  parameter int SAMPLES_PER_FRAME = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic [12:0]          max_skip,
  input  logic                 q_not_full,
  output logic                 ev_push,
  output adts_fsp_pkg::evt_t   ev
);

  localparam int TS_NUM = 90000 * SAMPLES_PER_FRAME;
  localparam logic [adts_fsp_pkg::INC_W-1:0] INC_TAB [16] = '{
    adts_fsp_pkg::INC_W'(TS_NUM / 96000), adts_fsp_pkg::INC_W'(TS_NUM / 88200),
    adts_fsp_pkg::INC_W'(TS_NUM / 64000), adts_fsp_pkg::INC_W'(TS_NUM / 48000),
    adts_fsp_pkg::INC_W'(TS_NUM / 44100), adts_fsp_pkg::INC_W'(TS_NUM / 32000),
    adts_fsp_pkg::INC_W'(TS_NUM / 24000), adts_fsp_pkg::INC_W'(TS_NUM / 22050),
    adts_fsp_pkg::INC_W'(TS_NUM / 16000), adts_fsp_pkg::INC_W'(TS_NUM / 12000),
    adts_fsp_pkg::INC_W'(TS_NUM / 11025), adts_fsp_pkg::INC_W'(TS_NUM / 8000),
    adts_fsp_pkg::INC_W'(TS_NUM / 7350), '0, '0, '0
  };

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        held_r, held_nxt;
  logic [12:0] skip_r, skip_nxt;
  logic [12:0] pos_r, pos_nxt;
  logic [12:0] len_r, len_nxt;
  logic [adts_fsp_pkg::TS_W-1:0] ts_r, ts_nxt;
  logic [7:0]  hb_r [adts_fsp_pkg::HDR_MAX];
  logic        hb_we;
  logic [3:0]  hb_idx;

  logic        accept;
  logic [79:0] hv;
  logic [3:0]  hl;
  logic        id, pa;
  adts_fsp_pkg::hdr_t hdr;

  assign in_ready = q_not_full;
  assign accept   = in_valid && in_ready;
  assign hl = {2'b0, ~hb_r[1][0], 1'b0} + {3'b0, ~hb_r[1][3]} + 4'd7;

  // Header bits MSB first, with the incoming byte placed at its slot. Byte 0 is
  // always the sync byte.
  always_comb begin
    hv[79 -: 8] = adts_fsp_pkg::SYNC_BYTE;
    for (int i = 1; i < adts_fsp_pkg::HDR_MAX; i++) begin
      hv[79 - 8*i -: 8] = (pos_r[3:0] == 4'(i)) ? in_data_byte : hb_r[i];
    end
  end

  always_comb begin
    id = hv[67];
    pa = hv[64];
    hdr.mpeg_id    = id;
    hdr.profile    = hv[63:62];
    hdr.rate_index = hv[61:58];
    hdr.channels   = (hv[56:54] > 3'd6) ? 3'd2 : hv[56:54];
    hdr.timestamp  = ts_r;
    hdr.misc_flags[9]   = pa;
    hdr.misc_flags[8]   = hv[57];
    hdr.misc_flags[7]   = hv[53];
    hdr.misc_flags[6]   = hv[52];
    if (id) begin
      hdr.misc_flags[5:4] = hv[51:50];
      hdr.misc_flags[3:2] = 2'b0;
      hdr.misc_flags[1:0] = hv[25:24];
      hdr.frame_length    = hv[49:37];
      hdr.buffer_fullness = hv[36:26];
      hdr.check_word      = pa ? 16'd0 : hv[23:8];
    end else begin
      hdr.misc_flags[5:4] = hv[49:48];
      hdr.misc_flags[3:2] = hv[51:50];
      hdr.misc_flags[1:0] = hv[23:22];
      hdr.frame_length    = hv[47:35];
      hdr.buffer_fullness = hv[34:24];
      hdr.check_word      = pa ? 16'd0 : hv[21:6];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    held_nxt  = held_r;
    skip_nxt  = skip_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    ts_nxt    = ts_r;
    hb_we     = 1'b0;
    hb_idx    = pos_r[3:0];
    ev_push   = 1'b0;
    ev.code      = adts_fsp_pkg::EV_BYTE;
    ev.data      = in_data_byte;
    ev.last      = 1'b0;
    ev.info_kind = adts_fsp_pkg::KIND_INFO;
    ev.hdr       = hdr;
    if (accept) begin
      case (phase_r)
        adts_fsp_pkg::PH_HUNT: begin
          if (held_r && prev_r == adts_fsp_pkg::SYNC_BYTE &&
              (in_data_byte & adts_fsp_pkg::SYNC_MASK) == adts_fsp_pkg::SYNC_VAL) begin
            // Byte 0 is always 0xFF; only byte 1 needs storing.
            hb_we     = 1'b1;
            hb_idx    = 4'd1;
            pos_nxt   = 13'd2;
            phase_nxt = adts_fsp_pkg::PH_HEAD;
            ev_push   = 1'b1;
            ev.code   = adts_fsp_pkg::EV_PAIR;
          end else if (held_r && skip_r >= max_skip) begin
            phase_nxt = adts_fsp_pkg::PH_STOP;
            ev_push   = 1'b1;
            ev.code   = adts_fsp_pkg::EV_LOST;
          end else begin
            if (held_r) begin
              skip_nxt = skip_r + 13'd1;
            end
            prev_nxt = in_data_byte;
            held_nxt = 1'b1;
          end
        end
        adts_fsp_pkg::PH_HEAD: begin
          hb_we   = 1'b1;
          pos_nxt = pos_r + 13'd1;
          ev_push = 1'b1;
          if (pos_r[3:0] + 4'd1 == hl) begin
            ev.code = adts_fsp_pkg::EV_INFO;
            if (hdr.frame_length < {9'd0, hl}) begin
              ev.info_kind = adts_fsp_pkg::KIND_SHORT;
              phase_nxt = adts_fsp_pkg::PH_HUNT;
              prev_nxt  = '0;
              held_nxt  = 1'b0;
              skip_nxt  = '0;
              pos_nxt   = '0;
            end else begin
              ts_nxt = ts_r + adts_fsp_pkg::TS_W'(INC_TAB[hdr.rate_index]);
              if (hdr.frame_length == {9'd0, hl}) begin
                ev.last   = 1'b1;
                phase_nxt = adts_fsp_pkg::PH_HUNT;
                prev_nxt  = '0;
                held_nxt  = 1'b0;
                skip_nxt  = '0;
                pos_nxt   = '0;
              end else begin
                len_nxt   = hdr.frame_length;
                phase_nxt = adts_fsp_pkg::PH_BODY;
              end
            end
          end
        end
        adts_fsp_pkg::PH_BODY: begin
          ev_push = 1'b1;
          pos_nxt = pos_r + 13'd1;
          if (pos_r + 13'd1 >= len_r) begin
            ev.last   = 1'b1;
            phase_nxt = adts_fsp_pkg::PH_HUNT;
            prev_nxt  = '0;
            held_nxt  = 1'b0;
            skip_nxt  = '0;
            pos_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= adts_fsp_pkg::PH_HUNT;
      prev_r  <= '0;
      held_r  <= 1'b0;
      skip_r  <= '0;
      pos_r   <= '0;
      len_r   <= '0;
      ts_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      held_r  <= held_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      ts_r    <= ts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hb_we) begin
      hb_r[hb_idx] <= in_data_byte;
    end
  end

endmodule

// ===== rtl/adts_fsp_back.sv =====
module adts_fsp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_not_empty,
  input  adts_fsp_pkg::evt_t              head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_frame_byte,
  output logic                            out_last_of_frame,
  output adts_fsp_pkg::hdr_t              out_hdr
);

  logic               second_r, second_nxt;
  logic               vld_r;
  logic               load;
  logic               two;
  logic [1:0]         kind_c;
  logic [7:0]         byte_c;
  logic               last_c;
  adts_fsp_pkg::hdr_t hdr_c;
  logic [1:0]         kind_r;
  logic [7:0]         byte_r;
  logic               last_r;
  adts_fsp_pkg::hdr_t hdr_r;

  assign load = q_not_empty && (!vld_r || out_ready);
  assign two  = (head.code == adts_fsp_pkg::EV_PAIR) || (head.code == adts_fsp_pkg::EV_INFO);
  assign q_pop = load && (!two || second_r);
  assign second_nxt = load ? (two && !second_r) : second_r;

  always_comb begin
    kind_c = adts_fsp_pkg::KIND_BYTE;
    byte_c = '0;
    last_c = 1'b0;
    hdr_c  = '0;
    case (head.code)
      adts_fsp_pkg::EV_BYTE: begin
        byte_c = head.data;
        last_c = head.last;
      end
      adts_fsp_pkg::EV_PAIR: begin
        byte_c = second_r ? head.data : adts_fsp_pkg::SYNC_BYTE;
      end
      adts_fsp_pkg::EV_INFO: begin
        if (second_r) begin
          kind_c = head.info_kind;
          hdr_c  = head.hdr;
        end else begin
          byte_c = head.data;
          last_c = head.last;
        end
      end
      adts_fsp_pkg::EV_LOST: begin
        kind_c = adts_fsp_pkg::KIND_LOST;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_c;
      byte_r <= byte_c;
      last_r <= last_c;
      hdr_r  <= hdr_c;
    end
  end

  assign out_valid         = vld_r;
  assign out_kind          = kind_r;
  assign out_frame_byte    = byte_r;
  assign out_last_of_frame = last_r;
  assign out_hdr           = hdr_r;

endmodule

// ===== rtl/adts_fsp_checker.sv =====
`include "adts_frame_sync_parser_macros.svh"

module adts_fsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_frame_byte,
  input logic        out_last_of_frame,
  input logic [2:0]  out_channels,
  input logic [12:0] out_frame_length,
  input logic [32:0] out_timestamp
);

  `AFSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_frame_byte), "output request dropped or changed while stalled")
  `AFSP_ASSERT(a_byte_clean, out_valid && out_kind == adts_fsp_pkg::KIND_BYTE |-> out_frame_length == 13'd0 && out_timestamp == 33'd0, "frame byte carries header fields")
  `AFSP_ASSERT(a_info_chan, out_valid && out_kind == adts_fsp_pkg::KIND_INFO |-> out_channels <= 3'd6 && !out_last_of_frame, "header info malformed")
  `AFSP_ASSERT(a_lost_clean, out_valid && out_kind == adts_fsp_pkg::KIND_LOST |-> out_frame_byte == 8'd0 && out_frame_length == 13'd0, "sync-lost report carries data")

endmodule

bind adts_frame_sync_parser adts_fsp_checker u_chk (.*);

// ===== tb/adts_frame_sync_parser_tb.sv =====
`default_nettype none

// One result as it leaves the block.
typedef struct packed {
  logic [1:0]  kind;
  logic [7:0]  frame_byte;
  logic        last_of_frame;
  logic        mpeg_id;
  logic [1:0]  profile;
  logic [3:0]  rate_index;
  logic [2:0]  channels;
  logic [12:0] frame_length;
  logic [10:0] buffer_fullness;
  logic [15:0] check_word;
  logic [9:0]  misc_flags;
  logic [32:0] timestamp;
} adts_result_t;

// Parser shadow: follows the byte stream and keeps the results it must produce.
class adts_frame_checker;
  logic [12:0]  max_skip;
  logic [1:0]   phase;
  logic [7:0]   prev_byte;
  int unsigned  skip_count;
  logic [7:0]   hdr [adts_fsp_pkg::HDR_MAX];
  int unsigned  position;
  int unsigned  frame_len;
  logic [32:0]  clock_90k;
  adts_result_t expected_results[$];
  int           errors;

  function new();
    max_skip  = 13'd8000;
    frame_len = 0;
    clock_90k = '0;
    errors    = 0;
    foreach (hdr[i]) hdr[i] = '0;
    resync();
  endfunction

  function void resync();
    phase      = adts_fsp_pkg::PH_HUNT;
    prev_byte  = '0;
    skip_count = 0;
    position   = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Header bits are numbered from the MSB of the first header byte.
  function logic [15:0] bits_at(int p, int n);
    logic [79:0] hv;
    logic [79:0] t;
    hv = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7], hdr[8], hdr[9]};
    t  = hv << p;
    return t[79 -: 16] >> (16 - n);
  endfunction

  function int header_length();
    int nbits;
    nbits = 56;
    if (!hdr[1][3]) nbits += 2;
    if (!hdr[1][0]) nbits += 16;
    return (nbits + 7) / 8;
  endfunction

  function logic [32:0] frame_ticks(logic [3:0] idx);
    int unsigned hz;
    case (idx)
      4'd0: hz = 96000;   4'd1: hz = 88200;   4'd2: hz = 64000;   4'd3: hz = 48000;
      4'd4: hz = 44100;   4'd5: hz = 32000;   4'd6: hz = 24000;   4'd7: hz = 22050;
      4'd8: hz = 16000;   4'd9: hz = 12000;   4'd10: hz = 11025; 4'd11: hz = 8000;
      4'd12: hz = 7350;
      default: hz = 0;
    endcase
    if (hz == 0) return '0;
    return 33'(64'd90000 * 64'd1024 / hz);
  endfunction

  function void push_byte(logic [7:0] b, logic last);
    adts_result_t r;
    r = '0;
    r.kind          = adts_fsp_pkg::KIND_BYTE;
    r.frame_byte    = b;
    r.last_of_frame = last;
    expected_results.push_back(r);
  endfunction

  function adts_result_t parse_header(logic [1:0] kind);
    adts_result_t r;
    int           e;
    r = '0;
    r.kind       = kind;
    r.mpeg_id    = 1'(bits_at(12, 1));
    e            = r.mpeg_id ? 0 : 2;
    r.profile    = 2'(bits_at(16, 2));
    r.rate_index = 4'(bits_at(18, 4));
    r.channels   = 3'(bits_at(23, 3));
    if (r.channels > 3'd6) r.channels = 3'd2;
    r.frame_length    = 13'(bits_at(30 + e, 13));
    r.buffer_fullness = 11'(bits_at(43 + e, 11));
    r.check_word      = bits_at(15, 1) != 16'd0 ? 16'd0 : bits_at(56 + e, 16);
    r.misc_flags = {bits_at(15, 1) == 16'd1, bits_at(22, 1) == 16'd1,
                    bits_at(26, 1) == 16'd1, bits_at(27, 1) == 16'd1,
                    bits_at(28 + e, 1) == 16'd1, bits_at(29 + e, 1) == 16'd1,
                    r.mpeg_id ? 2'b00 : 2'(bits_at(28, 2)), 2'(bits_at(54 + e, 2))};
    r.timestamp  = clock_90k;
    return r;
  endfunction

  function void note_byte(logic [7:0] b);
    adts_result_t info;
    adts_result_t lost;
    int           hl;
    case (phase)
      adts_fsp_pkg::PH_STOP: ;
      adts_fsp_pkg::PH_HUNT: begin
        if (position != 0 && prev_byte == adts_fsp_pkg::SYNC_BYTE &&
            (b & adts_fsp_pkg::SYNC_MASK) == adts_fsp_pkg::SYNC_VAL) begin
          hdr[0]   = adts_fsp_pkg::SYNC_BYTE;
          hdr[1]   = b;
          position = 2;
          phase    = adts_fsp_pkg::PH_HEAD;
          push_byte(adts_fsp_pkg::SYNC_BYTE, 1'b0);
          push_byte(b, 1'b0);
        end else if (position != 0 && skip_count >= max_skip) begin
          lost      = '0;
          lost.kind = adts_fsp_pkg::KIND_LOST;
          expected_results.push_back(lost);
          phase = adts_fsp_pkg::PH_STOP;
        end else begin
          if (position != 0) skip_count++;
          prev_byte = b;
          position  = 1;
        end
      end
      adts_fsp_pkg::PH_HEAD: begin
        hdr[position % adts_fsp_pkg::HDR_MAX] = b;
        position++;
        hl = header_length();
        if (position < hl) begin
          push_byte(b, 1'b0);
        end else begin
          info = parse_header(adts_fsp_pkg::KIND_INFO);
          if (info.frame_length < hl) begin
            // Frame claims to be shorter than its own header: reported, then dropped.
            info.kind = adts_fsp_pkg::KIND_SHORT;
            push_byte(b, 1'b0);
            expected_results.push_back(info);
            resync();
          end else begin
            clock_90k = clock_90k + frame_ticks(info.rate_index);
            push_byte(b, info.frame_length == hl);
            expected_results.push_back(info);
            if (info.frame_length == hl) begin
              resync();
            end else begin
              frame_len = 32'(info.frame_length);
              phase     = adts_fsp_pkg::PH_BODY;
            end
          end
        end
      end
      default: begin
        position++;
        push_byte(b, position >= frame_len);
        if (position >= frame_len) resync();
      end
    endcase
  endfunction

  function void check_result(adts_result_t got);
    adts_result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected request: %p", got);
      return;
    end
    want = expected_results.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch:\n  expected %p\n  actual   %p", want, got);
    end
  endfunction
endclass

module adts_frame_sync_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake on any channel before the run is declared hung. The
  // longest legitimate quiet stretch is a sender gap or the receiver hold-off.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int ITEM_TARGET    = 1400;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [12:0]  cfg_max_skip = '0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [7:0]   in_data_byte = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [1:0]   out_kind;
  logic [7:0]   out_frame_byte;
  logic         out_last_of_frame;
  logic         out_mpeg_id;
  logic [1:0]   out_profile;
  logic [3:0]   out_rate_index;
  logic [2:0]   out_channels;
  logic [12:0]  out_frame_length;
  logic [10:0]  out_buffer_fullness;
  logic [15:0]  out_check_word;
  logic [9:0]   out_misc_flags;
  logic [32:0]  out_timestamp;

  adts_frame_checker parser_shadow = new();

  int bytes_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int rx_cycle = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  adts_frame_sync_parser u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_skip        (cfg_max_skip),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_frame_byte      (out_frame_byte),
    .out_last_of_frame   (out_last_of_frame),
    .out_mpeg_id         (out_mpeg_id),
    .out_profile         (out_profile),
    .out_rate_index      (out_rate_index),
    .out_channels        (out_channels),
    .out_frame_length    (out_frame_length),
    .out_buffer_fullness (out_buffer_fullness),
    .out_check_word      (out_check_word),
    .out_misc_flags      (out_misc_flags),
    .out_timestamp       (out_timestamp)
  );

  // Every accepted result request is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      parser_shadow.check_result({out_kind, out_frame_byte, out_last_of_frame, out_mpeg_id,
                                  out_profile, out_rate_index, out_channels,
                                  out_frame_length, out_buffer_fullness, out_check_word,
                                  out_misc_flags, out_timestamp});
    end
  end

  // The watchdog counts cycles in which no channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("adts_frame_sync_parser_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver steps through four stall patterns in turn. Once, early in the run
  // while the sender is busy, a long hold-off lets the event queue fill so that the
  // block has to stall its input.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 400 && rx_cycle < 800) begin
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Offers one byte and waits for its request to be accepted. The sender works in
  // bursts; between bursts valid may drop for a random number of cycles.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    do @(posedge clk); while (!in_ready);
    parser_shadow.note_byte(b);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Lets the parser drain, then writes max_skip while nothing is in flight.
  task automatic write_max_skip(input logic [12:0] v);
    in_valid = 1'b0;
    while (parser_shadow.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid    = 1'b1;
    cfg_max_skip = v;
    do @(posedge clk); while (!cfg_ready);
    parser_shadow.max_skip = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sends one frame. The header is random apart from the sync pattern, the id and
  // protection bits, and the length; forced channel or rate codes use -1 for random.
  task automatic send_frame(input int id, input int absent, input int flen,
                            input int chan, input int rate);
    logic [79:0] hv;
    int          e;
    int          hl;
    int          total;
    hv = {$urandom, $urandom, 16'($urandom)};
    hv[79 -: 16] = {adts_fsp_pkg::SYNC_BYTE, 4'hF, id[0], 2'b00, absent[0]};
    e  = id ? 0 : 2;
    hl = (56 + e + (absent ? 0 : 16) + 7) / 8;
    if (flen < 0) flen = hl + $urandom_range(0, 24);
    if (chan >= 0) hv[79 - 23 -: 3] = chan[2:0];
    if (rate >= 0) hv[79 - 18 -: 4] = rate[3:0];
    hv[79 - 30 - e -: 13] = flen[12:0];
    // A frame shorter than its header ends right after the header.
    total = (flen < hl) ? hl : flen;
    for (int i = 0; i < total; i++) begin
      if (i < hl) send_byte(hv[79 - 8 * i -: 8]);
      else send_byte(8'($urandom));
    end
  endtask

  // Bytes that cannot sync. Some are a lone 0xFF followed by a byte with layer bits.
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0 && i + 1 < count) begin
        send_byte(adts_fsp_pkg::SYNC_BYTE);
        send_byte(8'($urandom_range(0, 254)) | 8'h02);
        i++;
      end else begin
        send_byte(8'($urandom_range(0, 254)));
      end
    end
  endtask

  // A frame of random shape: mostly ordinary, sometimes header-only or too short.
  task automatic send_random_frame();
    int pick;
    int id;
    int absent;
    id     = $urandom_range(0, 1);
    absent = $urandom_range(0, 1);
    pick   = $urandom_range(0, 39);
    if (pick == 0) send_frame(id, absent, $urandom_range(0, 6), -1, -1);
    else if (pick < 4) send_frame(id, absent, (56 + (id ? 0 : 2) + (absent ? 0 : 16) + 7) / 8,
                                  -1, -1);
    else send_frame(id, absent, -1, -1, -1);
  endtask

  initial begin
    int limit;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part with the reset value of max_skip: every header layout, a
    // header-only frame, a frame shorter than its header, channel code 7, a
    // reserved rate index and a broken sync pair.
    send_noise(3);
    send_frame(0, 0, -1, 7, 13);
    send_frame(1, 1, 7, 0, 0);
    send_frame(0, 1, 2, -1, 12);
    send_byte(adts_fsp_pkg::SYNC_BYTE);
    send_byte(adts_fsp_pkg::SYNC_BYTE);
    send_byte(8'hF2);
    send_frame(1, 0, 0, 6, 15);
    send_frame(1, 0, -1, -1, 3);

    // Widest skip allowance, with noise and one long frame.
    write_max_skip(13'd8191);
    send_frame(0, 0, 300, -1, -1);
    while (bytes_sent < ITEM_TARGET / 2) begin
      send_noise($urandom_range(0, 30));
      send_random_frame();
    end

    // No skipping allowed: frames must follow each other back to back.
    write_max_skip(13'd0);
    for (int i = 0; i < 12; i++) send_random_frame();

    // A middle setting with noise just up to the limit now and then.
    limit = $urandom_range(20, 60);
    write_max_skip(13'(limit));
    while (bytes_sent < ITEM_TARGET) begin
      send_noise($urandom_range(0, 3) == 0 ? limit : $urandom_range(0, limit));
      send_random_frame();
    end

    // A small limit and endless noise: the hunt gives up once, then input is dropped.
    write_max_skip(13'd4);
    send_noise(30);

    in_valid = 1'b0;
    while (parser_shadow.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (parser_shadow.errors == 0 && parser_shadow.pending() == 0) begin
      $display("adts_frame_sync_parser_tb: done, clean");
    end else begin
      $display("adts_frame_sync_parser_tb: done, errors");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== adts_frame_sync_parser.f =====
+incdir+rtl
rtl/adts_fsp_pkg.sv
rtl/adts_fsp_queue.sv
rtl/adts_fsp_front.sv
rtl/adts_fsp_back.sv
rtl/adts_frame_sync_parser.sv
rtl/adts_fsp_checker.sv
tb/adts_frame_sync_parser_tb.sv
